[hdl/fap_pkg.sv]
package fap_pkg;

   // Fixed widths of the word fields.
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 32;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 4;
   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Default table depth.
   localparam int FAP_NUM_BLOCKS = 16;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   // Fit modes; the unused code behaves as first fit.
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

   // Operation class decided by the front.
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_SKIP,
      OP_REQ
   } op_type;

   // One classified word waiting in the queue.
   typedef struct packed {
      op_type                op;
      logic [SLOT_W-1:0]     slot;
      logic [AMOUNT_W-1:0]   amount;
      logic                  last;
   } work_type;

   // Back engine states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

[hdl/fap_front.sv]
module fap_front
   import fap_pkg::*;
#(
   parameter int NUM_BLOCKS = FAP_NUM_BLOCKS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                req_last_request,
   output logic                q_valid,
   output work_type            q_data,
   input  logic                q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   work_type             classified;
   logic                 push;

   // Classify the incoming word: request, load in range, or load that misses the table.
   always_comb begin
      classified.slot   = req_slot_index;
      classified.amount = req_amount;
      classified.last   = req_last_request;
      if (req_kind) begin
         classified.op = OP_REQ;
      end else if ({{(32-SLOT_W){1'b0}}, req_slot_index} < 32'(NUM_BLOCKS)) begin
         classified.op = OP_LOAD;
      end else begin
         classified.op = OP_SKIP;
      end
   end

   assign req_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != '0);
   assign q_data    = entry_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[hdl/fap_back.sv]
module fap_back
   import fap_pkg::*;
#(
   parameter int NUM_BLOCKS = FAP_NUM_BLOCKS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [MODE_W-1:0]   fit_mode,
   input  logic [COUNT_W-1:0]  block_count,
   input  logic                q_valid,
   input  work_type            q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GRANT_W-1:0]  rsp_granted_index
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   state_type               state_ff, state_in;
   work_type                cur_ff, cur_in;
   logic [CNT_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic                    pick_vld_ff, pick_vld_in;
   logic [IDX_W-1:0]        pick_idx_ff, pick_idx_in;
   logic [AMOUNT_W-1:0]     pick_size_ff, pick_size_in;
   logic [NUM_BLOCKS-1:0]   used_ff, used_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [GRANT_W-1:0]      rsp_index_ff, rsp_index_in;

   logic [AMOUNT_W-1:0]     size_mem [NUM_BLOCKS];
   logic [AMOUNT_W-1:0]     rdata_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        wr_addr;
   logic [IDX_W-1:0]        rd_addr;

   logic [CNT_W-1:0]        limit;
   logic                    out_free;
   logic                    eligible;
   logic                    take;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic [IDX_W+GRANT_W-1:0] pick_ext;

   // Partitions searched: the configured count, capped at the table depth.
   always_comb begin
      if ({{(32-COUNT_W){1'b0}}, block_count} > 32'(NUM_BLOCKS)) begin
         limit = CNT_W'(NUM_BLOCKS);
      end else begin
         limit = CNT_W'(block_count);
      end
   end

   assign slot_ext = {{IDX_W{1'b0}}, cur_ff.slot};
   assign wr_addr  = slot_ext[IDX_W-1:0];
   assign pick_ext = {{GRANT_W{1'b0}}, pick_idx_ff};
   assign rd_addr  = rd_ptr_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Candidate check on the size read back from the previous cycle.
   always_comb begin
      eligible = chk_vld_ff && !used_ff[chk_idx_ff] && (rdata_ff >= cur_ff.amount);
      take     = 1'b0;
      if (eligible) begin
         if (!pick_vld_ff) begin
            take = 1'b1;
         end else if (fit_mode == FIT_BEST) begin
            take = (rdata_ff < pick_size_ff);
         end else if (fit_mode == FIT_WORST) begin
            take = (rdata_ff > pick_size_ff);
         end
      end
   end

   // Sequencer: pop a word, then load, or scan and commit.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      pick_vld_in   = pick_vld_ff;
      pick_idx_in   = pick_idx_ff;
      pick_size_in  = pick_size_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      mem_we        = 1'b0;
      q_pop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               if (q_data.op == OP_REQ) begin
                  rd_ptr_in   = '0;
                  chk_vld_in  = 1'b0;
                  pick_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            if (out_free) begin
               if (cur_ff.op == OP_LOAD) begin
                  mem_we           = 1'b1;
                  used_in[wr_addr] = 1'b0;
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_LOADED;
               rsp_index_in  = '0;
               state_in      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle while partitions remain.
            chk_vld_in = 1'b0;
            if (rd_ptr_ff < limit) begin
               chk_vld_in = 1'b1;
               chk_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in  = rd_ptr_ff + 1'b1;
            end else if (!chk_vld_ff) begin
               state_in = ST_COMMIT;
            end
            if (take) begin
               pick_vld_in  = 1'b1;
               pick_idx_in  = chk_idx_ff;
               pick_size_in = rdata_ff;
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pick_vld_ff) begin
                  used_in[pick_idx_ff] = 1'b1;
                  rsp_status_in        = STATUS_GRANTED;
                  rsp_index_in         = pick_ext[GRANT_W-1:0];
               end else begin
                  rsp_status_in = STATUS_REFUSED;
                  rsp_index_in  = '0;
               end
               // The last request of a job frees every partition afterwards.
               if (cur_ff.last) begin
                  used_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         pick_vld_ff  <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         pick_vld_ff  <= pick_vld_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rd_ptr_ff     <= rd_ptr_in;
      chk_idx_ff    <= chk_idx_in;
      pick_idx_ff   <= pick_idx_in;
      pick_size_ff  <= pick_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // Partition size memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[wr_addr] <= cur_ff.amount;
      end
      rdata_ff <= size_mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;

endmodule

[hdl/fixed_partition_fit_allocator.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  kind, slot_index, amount, last_request
// rsp_      out        rsp_valid/rsp_ready  status, granted_index
// csr_      in         csr_write_en         csr_index, csr_wdata
//
// A load word is queued, then popped into ST_LOAD, which registers its result.
// A request scans min(block_count, NUM_BLOCKS) partitions: the size memory has one
// read port, so the scan checks one partition per cycle; then the result commits.
// The front queues two words while the back is busy, and the back holds a finished
// result in its output register until rsp_ready.
// Reset clears the configuration, the queue and every used bit; sizes are kept.
module fixed_partition_fit_allocator
   import fap_pkg::*;
#(
   parameter int NUM_BLOCKS = FAP_NUM_BLOCKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [SLOT_W-1:0]     req_slot_index,
   input  logic [AMOUNT_W-1:0]   req_amount,
   input  logic                  req_last_request,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [GRANT_W-1:0]    rsp_granted_index,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MODE_W-1:0]  fit_mode_ff;
   logic [COUNT_W-1:0] block_count_ff;
   logic               q_valid;
   work_type           q_data;
   logic               q_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_FIRST;
         block_count_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FIT_MODE:    fit_mode_ff    <= csr_wdata[MODE_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fap_front #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_slot_index  (req_slot_index),
      .req_amount      (req_amount),
      .req_last_request(req_last_request),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop)
   );

   fap_back #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .fit_mode         (fit_mode_ff),
      .block_count      (block_count_ff),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_index(rsp_granted_index)
   );

endmodule
